FILE: rtl/spq_pkg.sv
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_USED_W  = 3 * DATA_W + CNT_W;

    typedef enum logic
    {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        logic signed [DATA_W-1:0] item;
        logic signed [DATA_W-1:0] pri;
    } entry_t;

    typedef struct packed
    {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
module spq_cell
(
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic                front,
    input  logic                valid,
    input  logic                keep_left,
    input  spq_pkg::entry_t     new_entry,
    input  spq_pkg::entry_t     left_entry,
    input  spq_pkg::entry_t     right_entry,
    output spq_pkg::entry_t     entry,
    output logic                keep
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   beats;
    logic   ties;

    // compare against the incoming priority
    assign beats = valid && (entry_reg.pri > new_entry.pri);
    assign ties  = valid && (entry_reg.pri >= new_entry.pri);
    // the front entry holds its place on equal priority
    assign keep  = front ? ties : beats;
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (!keep)
            begin
                entry_next = keep_left ? new_entry : left_entry;
            end
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: rtl/sorted_priority_queue_top.sv
// channel | dir | tdata (low bit up)                               | tuser
// s_axis  | in  | item_value[31:0], item_priority[63:32]           | cmd
// m_axis  | out | removed_item, removed_priority, front_item,       | status
//         |     | entry_count[100:96], zero pad to 104 bits        |
// one transaction per cycle unless stalled: every cell compares and shifts in parallel
// the result is registered; a new transaction is taken while the result register
// is empty or being drained
// reset clears the entry count and the output valid flag
// a stalled result blocks further input until it is taken
module sorted_priority_queue_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [spq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // item_value, item_priority
    input  logic                              s_axis_tuser,   // cmd
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [spq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // removed_item, removed_priority,
                                                              // front_item, entry_count
    output logic [1:0]                        m_axis_tuser    // status
);
    import spq_pkg::*;

    logic                     in_acc;
    entry_t                   new_entry;
    cmd_t                     cmd;
    cell_ctrl_t               ctrl;
    logic                     is_full;
    logic                     queue_empty;

    entry_t                   cells       [QUEUE_DEPTH];
    logic   [QUEUE_DEPTH-1:0] keep;
    logic   [QUEUE_DEPTH-1:0] valid;

    logic   [CNT_W-1:0]       count_reg;
    logic   [CNT_W-1:0]       count_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [DATA_W-1:0] rem_item_reg;
    logic signed [DATA_W-1:0] rem_item_next;
    logic signed [DATA_W-1:0] rem_pri_reg;
    logic signed [DATA_W-1:0] rem_pri_next;
    logic signed [DATA_W-1:0] front_reg;
    logic signed [DATA_W-1:0] front_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cmd           = cmd_t'(s_axis_tuser);
    assign new_entry.item = s_axis_tdata[DATA_W-1:0];
    assign new_entry.pri  = s_axis_tdata[2*DATA_W-1:DATA_W];

    assign is_full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign queue_empty = (count_reg == '0);

    assign ctrl.enq = in_acc && (cmd == CMD_ENQ) && !is_full;
    assign ctrl.deq = in_acc && (cmd == CMD_DEQ) && !queue_empty;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            assign valid[i] = (count_reg > CNT_W'(i));
            if (i == 0)
            begin : g_front
                spq_cell u_cell
                (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .front       (1'b1),
                    .valid       (valid[i]),
                    .keep_left   (1'b1),
                    .new_entry   (new_entry),
                    .left_entry  (new_entry),
                    .right_entry (cells[(i + 1) % QUEUE_DEPTH]),
                    .entry       (cells[i]),
                    .keep        (keep[i])
                );
            end
            else
            begin : g_rest
                spq_cell u_cell
                (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .front       (1'b0),
                    .valid       (valid[i]),
                    .keep_left   (keep[i-1]),
                    .new_entry   (new_entry),
                    .left_entry  (cells[i-1]),
                    .right_entry (cells[(i + 1) % QUEUE_DEPTH]),
                    .entry       (cells[i]),
                    .keep        (keep[i])
                );
            end
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        status_next    = status_reg;
        rem_item_next  = rem_item_reg;
        rem_pri_next   = rem_pri_reg;
        front_next     = front_reg;
        if (in_acc)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            rem_item_next  = '0;
            rem_pri_next   = '0;
            front_next     = queue_empty ? -32'sd1 : cells[0].item;
            if (cmd == CMD_ENQ)
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    front_next = keep[0] ? cells[0].item : new_entry.item;
                end
            end
            else
            begin
                if (queue_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next    = count_reg - CNT_W'(1);
                    rem_item_next = cells[0].item;
                    rem_pri_next  = cells[0].pri;
                    front_next    = valid[1] ? cells[1].item : -32'sd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        rem_item_reg <= rem_item_next;
        rem_pri_reg  <= rem_pri_next;
        front_reg    <= front_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, count_reg, front_reg,
                            rem_pri_reg, rem_item_reg};

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_enq_count : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.enq |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("enqueue did not grow count");

    a_empty_front : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (count_reg == '0) |-> front_reg == -32'sd1)
        else $error("front item not -1 on empty queue");

    a_deq_front : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.deq |=> rem_pri_reg == $past(cells[0].pri))
        else $error("dequeue returned wrong priority");

    a_sorted_front : assert property (@(posedge clk) disable iff (!rst_n)
        valid[1] |-> cells[0].pri >= cells[1].pri)
        else $error("front entry out of order");
`endif

endmodule
